### src/column_mean_and_std_dev_assert.svh
// Assertion macros for the column statistics block.
`ifndef COLUMN_MEAN_AND_STD_DEV_ASSERT_SVH
`define COLUMN_MEAN_AND_STD_DEV_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CMSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmsd: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CMSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmsd: next-cycle check failed");

`endif

### src/cmsd_pkg.sv
// Shared field widths of the column statistics block.
`timescale 1ns / 1ps
package cmsd_pkg;
  localparam int ROW_W = 8;
  localparam int COL_W = 4;
  localparam int Z_W   = 25;
  localparam int H_W   = 15;
  localparam int CFG_W = 9;
endpackage

### src/column_mean_and_std_dev.sv
// After the item marked last, each column takes two row passes per value, first z then hydro:
// a sum pass over the n rows used, then a pass that sums the squared deviations.
// Load items are taken one per cycle while busy_o is low; a compute burst holds busy_o high.
// The restoring divider (shared by mean and root scaling) and the bit-serial square root run under one sequencer.
// Reset clears both stores in a pass over all MAX_ROWS*COLUMNS cells with busy_o high.
// Each result shows for one cycle on result_valid_o; the receiver cannot stall it.
`timescale 1ns / 1ps
module column_mean_and_std_dev #(
  parameter int MAX_ROWS = 256,
  parameter int COLUMNS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [cmsd_pkg::ROW_W-1:0]   row_index_i,
  input  logic [cmsd_pkg::COL_W-1:0]   column_index_i,
  input  logic [cmsd_pkg::Z_W-1:0]     z_value_i,
  input  logic [cmsd_pkg::H_W-1:0]     hydro_value_i,
  input  logic                         last_cell_i,
  input  logic                         rows_in_use_we_i,
  input  logic [cmsd_pkg::CFG_W-1:0]   rows_in_use_i,
  output logic                         result_valid_o,
  output logic [cmsd_pkg::COL_W-1:0]   column_out_o,
  output logic [cmsd_pkg::Z_W-1:0]     z_mean_o,
  output logic [cmsd_pkg::H_W-1:0]     hydro_mean_o,
  output logic [cmsd_pkg::Z_W-1:0]     z_std_dev_o,
  output logic [cmsd_pkg::H_W-1:0]     hydro_std_dev_o,
  output logic                         last_result_o
);
  import cmsd_pkg::*;

  localparam int CELLS = MAX_ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(MAX_ROWS + 1);
  localparam int MAGW  = Z_W - 1 + NW;
  localparam int SW    = MAGW + 1;
  localparam int DMW   = Z_W + 1;
  localparam int SQW   = 2 * DMW;
  localparam int QW    = SQW + NW;
  localparam int VW    = QW + NW;
  localparam int RW    = (VW + 1) / 2;
  localparam int DW    = (MAGW > RW) ? MAGW : RW;
  localparam int ITW   = $clog2(DW + 1);
  localparam int SRW   = RW + 3;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_MDIV  = 4'd3;
  localparam logic [3:0] ST_VAR   = 4'd4;
  localparam logic [3:0] ST_NQ    = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_SDIV  = 4'd7;

  // Stores.
  logic [Z_W-1:0] z_mem [CELLS];
  logic [H_W-1:0] h_mem [CELLS];

  logic [3:0]          state_q;
  logic [AW-1:0]       clr_q;
  logic [CFG_W-1:0]    rows_q;
  logic [NW-1:0]       n_q;
  logic [CW-1:0]       col_q;
  logic                ch_q;
  logic [NW-1:0]       cnt_q;
  logic [AW-1:0]       addr_q;
  logic                rd_vld_q;
  logic                sq_vld_q;
  logic [Z_W-1:0]      rdz_q;
  logic [H_W-1:0]      rdh_q;
  logic signed [SW-1:0] sum_q;
  logic                neg_q;
  logic [DW-1:0]       dvd_q;
  logic [NW-1:0]       rem_q;
  logic [ITW-1:0]      it_q;
  logic signed [Z_W-1:0] mean_q;
  logic [2*NW-1:0]     rsq_q;
  logic [SQW-1:0]      sq_q;
  logic [QW-1:0]       q_q;
  logic [VW-1:0]       v_q;
  logic [VW-1:0]       mq_q;
  logic [NW-1:0]       nsh_q;
  logic [2*RW-1:0]     vsh_q;
  logic [SRW-1:0]      srem_q;
  logic [RW-1:0]       root_q;
  logic [Z_W-1:0]      zmean_q;
  logic [Z_W-1:0]      zsd_q;
  logic                res_vld_q;
  logic [COL_W-1:0]    res_col_q;
  logic [Z_W-1:0]      res_zm_q;
  logic [H_W-1:0]      res_hm_q;
  logic [Z_W-1:0]      res_zs_q;
  logic [H_W-1:0]      res_hs_q;
  logic                res_last_q;

  // Load beat decode.
  logic          accept;
  logic          in_range;
  logic [AW-1:0] ld_addr;
  assign accept   = start_i && (state_q == ST_IDLE);
  assign in_range = (32'(row_index_i) < MAX_ROWS) && (32'(column_index_i) < COLUMNS);
  assign ld_addr  = AW'(32'(row_index_i) * COLUMNS + 32'(column_index_i));

  // Effective row count, clamped to one through MAX_ROWS.
  logic [NW-1:0] n_eff;
  always_comb begin
    if (rows_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      n_eff = NW'(MAX_ROWS);
    end else begin
      n_eff = NW'(rows_q);
    end
  end

  // Value of the channel being worked on, sign-extended to the z width.
  logic signed [Z_W-1:0] x_ext;
  assign x_ext = ch_q ? {{(Z_W - H_W){rdh_q[H_W-1]}}, rdh_q} : rdz_q;

  // Read issue for the two row passes.
  logic issue;
  assign issue = ((state_q == ST_SUM) || (state_q == ST_VAR)) && (cnt_q < n_q);

  // Sum magnitude.
  logic signed [SW-1:0] sum_neg;
  logic [MAGW-1:0]      sum_mag;
  assign sum_neg = -sum_q;
  assign sum_mag = sum_q[SW-1] ? sum_neg[MAGW-1:0] : sum_q[MAGW-1:0];

  // Deviation from the truncated mean and its square.
  logic signed [DMW-1:0] d_s;
  logic [DMW-1:0]        d_abs;
  logic [SQW-1:0]        sq_full;
  assign d_s     = DMW'(x_ext) - DMW'(mean_q);
  assign d_abs   = d_s[DMW-1] ? DMW'(-d_s) : DMW'(d_s);
  assign sq_full = d_abs * d_abs;

  // Restoring divider step, shared by the mean and the root scaling.
  logic [NW:0] dtrial;
  logic        dge;
  logic [NW:0] drem;
  assign dtrial = {rem_q, dvd_q[DW-1]};
  assign dge    = dtrial >= {1'b0, n_q};
  assign drem   = dge ? (dtrial - {1'b0, n_q}) : dtrial;

  // Bit-serial square root step.
  logic [SRW-1:0] srm;
  logic [SRW-1:0] strial;
  logic           sge;
  assign srm    = {srem_q[SRW-3:0], vsh_q[2*RW-1 -: 2]};
  assign strial = SRW'({root_q, 2'b01});
  assign sge    = srm >= strial;

  // Quotient and remainder views after the mean division.
  logic [Z_W-1:0]  quot;
  logic [2*NW-1:0] rem_sq;
  assign quot   = dvd_q[Z_W-1:0];
  assign rem_sq = rem_q * rem_q;

  logic last_col;
  assign last_col = (col_q == CW'(COLUMNS - 1));

  // Store writes: clearing pass after reset, else load beats.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      z_mem[clr_q] <= '0;
      h_mem[clr_q] <= '0;
    end else if (accept && in_range) begin
      z_mem[ld_addr] <= z_value_i;
      h_mem[ld_addr] <= hydro_value_i;
    end
    rdz_q <= z_mem[addr_q];
    rdh_q <= h_mem[addr_q];
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(1);
    end else if (rows_in_use_we_i) begin
      rows_q <= rows_in_use_i;
    end
  end

  // Sequencer and shared datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      n_q        <= NW'(1);
      col_q      <= '0;
      ch_q       <= 1'b0;
      cnt_q      <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      sq_vld_q   <= 1'b0;
      sum_q      <= '0;
      neg_q      <= 1'b0;
      dvd_q      <= '0;
      rem_q      <= '0;
      it_q       <= '0;
      mean_q     <= '0;
      rsq_q      <= '0;
      sq_q       <= '0;
      q_q        <= '0;
      v_q        <= '0;
      mq_q       <= '0;
      nsh_q      <= '0;
      vsh_q      <= '0;
      srem_q     <= '0;
      root_q     <= '0;
      zmean_q    <= '0;
      zsd_q      <= '0;
      res_vld_q  <= 1'b0;
      res_col_q  <= '0;
      res_zm_q   <= '0;
      res_hm_q   <= '0;
      res_zs_q   <= '0;
      res_hs_q   <= '0;
      res_last_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      rd_vld_q  <= issue;
      if (issue) begin
        cnt_q  <= cnt_q + NW'(1);
        addr_q <= addr_q + AW'(COLUMNS);
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && last_cell_i) begin
            n_q     <= n_eff;
            col_q   <= '0;
            ch_q    <= 1'b0;
            cnt_q   <= '0;
            addr_q  <= '0;
            sum_q   <= '0;
            state_q <= ST_SUM;
          end
        end
        // First pass: sum of the column.
        ST_SUM: begin
          if (rd_vld_q) begin
            sum_q <= sum_q + SW'(x_ext);
          end
          if (!issue && !rd_vld_q) begin
            neg_q   <= sum_q[SW-1];
            dvd_q   <= DW'(sum_mag);
            rem_q   <= '0;
            it_q    <= '0;
            state_q <= ST_MDIV;
          end
        end
        // Mean by restoring division, one quotient bit a cycle.
        ST_MDIV: begin
          if (it_q == ITW'(DW)) begin
            mean_q   <= neg_q ? -quot : quot;
            rsq_q    <= rem_sq;
            cnt_q    <= '0;
            addr_q   <= AW'(col_q);
            q_q      <= '0;
            sq_vld_q <= 1'b0;
            state_q  <= ST_VAR;
          end else begin
            rem_q <= drem[NW-1:0];
            dvd_q <= {dvd_q[DW-2:0], dge};
            it_q  <= it_q + ITW'(1);
          end
        end
        // Second pass: sum of squared deviations.
        ST_VAR: begin
          sq_vld_q <= rd_vld_q;
          sq_q     <= sq_full;
          if (sq_vld_q) begin
            q_q <= q_q + QW'(sq_q);
          end
          if (!issue && !rd_vld_q && !sq_vld_q) begin
            v_q     <= '0;
            mq_q    <= VW'(q_q);
            nsh_q   <= n_q;
            it_q    <= '0;
            state_q <= ST_NQ;
          end
        end
        // n*q by shift and add, then take away the squared remainder.
        ST_NQ: begin
          if (it_q == ITW'(NW)) begin
            vsh_q   <= (2*RW)'(v_q - VW'(rsq_q));
            srem_q  <= '0;
            root_q  <= '0;
            it_q    <= '0;
            state_q <= ST_SQRT;
          end else begin
            if (nsh_q[0]) begin
              v_q <= v_q + mq_q;
            end
            mq_q  <= mq_q << 1;
            nsh_q <= nsh_q >> 1;
            it_q  <= it_q + ITW'(1);
          end
        end
        // Integer square root, one root bit a cycle.
        ST_SQRT: begin
          if (it_q == ITW'(RW)) begin
            dvd_q   <= DW'(root_q);
            rem_q   <= '0;
            it_q    <= '0;
            state_q <= ST_SDIV;
          end else begin
            srem_q <= sge ? (srm - strial) : srm;
            root_q <= {root_q[RW-2:0], sge};
            vsh_q  <= vsh_q << 2;
            it_q   <= it_q + ITW'(1);
          end
        end
        // Root divided by n gives the deviation.
        ST_SDIV: begin
          if (it_q == ITW'(DW)) begin
            cnt_q <= '0;
            sum_q <= '0;
            if (!ch_q) begin
              zmean_q <= mean_q;
              zsd_q   <= dvd_q[Z_W-1:0];
              ch_q    <= 1'b1;
              addr_q  <= AW'(col_q);
              state_q <= ST_SUM;
            end else begin
              res_vld_q  <= 1'b1;
              res_col_q  <= COL_W'(col_q);
              res_zm_q   <= zmean_q;
              res_zs_q   <= zsd_q;
              res_hm_q   <= mean_q[H_W-1:0];
              res_hs_q   <= dvd_q[H_W-1:0];
              res_last_q <= last_col;
              ch_q       <= 1'b0;
              col_q      <= col_q + CW'(1);
              addr_q     <= AW'(col_q + CW'(1));
              state_q    <= last_col ? ST_IDLE : ST_SUM;
            end
          end else begin
            rem_q <= drem[NW-1:0];
            dvd_q <= {dvd_q[DW-2:0], dge};
            it_q  <= it_q + ITW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign result_valid_o  = res_vld_q;
  assign column_out_o    = res_col_q;
  assign z_mean_o        = res_zm_q;
  assign hydro_mean_o    = res_hm_q;
  assign z_std_dev_o     = res_zs_q;
  assign hydro_std_dev_o = res_hs_q;
  assign last_result_o   = res_last_q && res_vld_q;

  // Checks on the result stream.
`include "column_mean_and_std_dev_assert.svh"
  `CMSD_ASSERT_NOW(a_mid_result_busy, result_valid_o && !last_result_o, busy_o)
  `CMSD_ASSERT_NEXT(a_result_single, result_valid_o, !result_valid_o)
  `CMSD_ASSERT_NOW(a_last_ends_burst, result_valid_o && last_result_o, !busy_o)
endmodule
